@@ rtl/core/rfba_pkg.sv @@
// Shared types, constants and helper functions for the frame allocator.
`timescale 1ns / 1ps

package rfba_pkg;

   localparam int ADDR_W      = 48;
   localparam int CNT_W       = 16;
   localparam int FREE_W      = 17;
   localparam int OP_W        = 3;
   localparam int NUM_FRAMES  = 65536;
   localparam int FRAME_SHIFT = 12;
   localparam int FRAME_W     = $clog2(NUM_FRAMES);
   localparam int ROW_W       = 8;
   localparam int ROW_BITS    = 1 << ROW_W;
   localparam int ROWS_W      = FRAME_W - ROW_W;
   localparam int ROWS        = 1 << ROWS_W;
   localparam int SPAN_W      = ADDR_W - FRAME_SHIFT + 1;
   localparam int DELTA_W     = ROW_W + 1;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [FREE_W-1:0]   free_type;
   typedef logic [FRAME_W-1:0]  frame_type;
   typedef logic [ROWS_W-1:0]   rowaddr_type;
   typedef logic [ROW_BITS-1:0] row_type;
   typedef logic [ROW_W-1:0]    bitidx_type;
   typedef logic [DELTA_W-1:0]  delta_type;

   localparam op_type OP_ALLOC  = 3'd0;
   localparam op_type OP_FREE   = 3'd1;
   localparam op_type OP_ADDREF = 3'd2;
   localparam op_type OP_QUERY  = 3'd3;
   localparam op_type OP_RFREE  = 3'd4;
   localparam op_type OP_RUSED  = 3'd5;

   localparam cnt_type COUNT_MAX = '1;

   // Population count as a balanced adder tree.
   function automatic delta_type popcount(input row_type v);
      delta_type acc [ROW_BITS];
      for (int i = 0; i < ROW_BITS; i++) begin
         acc[i] = DELTA_W'(v[i]);
      end
      for (int lvl = 0; lvl < ROW_W; lvl++) begin
         for (int i = 0; i < (ROW_BITS >> (lvl + 1)); i++) begin
            acc[i] = acc[2*i] + acc[2*i+1];
         end
      end
      return acc[0];
   endfunction

   // Index of the lowest set bit; zero when none is set.
   function automatic bitidx_type lowest_set(input row_type v);
      bitidx_type idx;
      idx = '0;
      for (int i = ROW_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = ROW_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

@@ rtl/core/refcounted_frame_bitmap_allocator.sv @@
// Refcounted page-frame allocator: bitmap and count memories with RMW sequencer.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/req_stall | req_op, req_addr, req_end_addr
//  rsp     | out | rsp_valid/rsp_stall | rsp_alloc_addr, rsp_ref_count, rsp_free_frames
//
// Bitmap memory holds 256 rows of 256 used bits; the count memory holds one entry per frame.
// Allocate reads one bitmap row per cycle.
// Range ops read and write one row per cycle; rejected addresses, empty ranges and unknown ops
// skip from decode straight to the result.
// After reset a clearing pass writes every count entry, with req_stall high.
// rsp is held in an output register; the next beat is taken while a result is stalled.
`timescale 1ns / 1ps

module refcounted_frame_bitmap_allocator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rfba_pkg::op_type      req_op,
   input  rfba_pkg::addr_type    req_addr,
   input  rfba_pkg::addr_type    req_end_addr,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rfba_pkg::addr_type    rsp_alloc_addr,
   output rfba_pkg::cnt_type     rsp_ref_count,
   output rfba_pkg::free_type    rsp_free_frames
);
   import rfba_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_SINGLE = 3'd4;
   localparam logic [2:0] S_RANGE  = 3'd5;
   localparam logic [2:0] S_DRAIN  = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   row_type     bm_mem_ff [ROWS];
   cnt_type     rc_mem_ff [NUM_FRAMES];
   row_type     bm_rdata_ff;
   cnt_type     rc_rdata_ff;

   logic        bm_we, bm_re, rc_we, rc_re;
   rowaddr_type bm_waddr, bm_raddr;
   row_type     bm_wdata;
   frame_type   rc_waddr, rc_raddr;
   cnt_type     rc_wdata;

   logic [2:0]  state_ff, state_in;
   op_type      op_ff, op_in;
   addr_type    addr_ff, addr_in;
   addr_type    end_ff, end_in;
   addr_type    res_alloc_ff, res_alloc_in;
   cnt_type     res_cnt_ff, res_cnt_in;
   free_type    free_total_ff, free_total_in;
   rowaddr_type row_ff, row_in;
   frame_type   lo_ff, lo_in;
   frame_type   hi_ff, hi_in;
   delta_type   delta_ff, delta_in;
   logic        pend_ff, pend_in;
   frame_type   clr_ff, clr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   addr_type    rsp_alloc_ff, rsp_alloc_in;
   cnt_type     rsp_cnt_ff, rsp_cnt_in;
   free_type    rsp_free_ff, rsp_free_in;

   frame_type   frame;
   logic        addr_ok;
   logic [SPAN_W-1:0] first, last, last_c;
   row_type     cand, mask, new_row;
   bitidx_type  idx, lo_b, hi_b;
   logic        used;

   always_ff @(posedge clock) begin
      if (bm_we) begin
         bm_mem_ff[bm_waddr] <= bm_wdata;
      end
      if (bm_re) begin
         bm_rdata_ff <= bm_mem_ff[bm_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (rc_we) begin
         rc_mem_ff[rc_waddr] <= rc_wdata;
      end
      if (rc_re) begin
         rc_rdata_ff <= rc_mem_ff[rc_raddr];
      end
   end

   assign frame   = addr_ff[FRAME_SHIFT +: FRAME_W];
   assign addr_ok = (addr_ff != '0) && (addr_ff[FRAME_SHIFT-1:0] == '0) &&
                    (addr_ff[ADDR_W-1:FRAME_SHIFT+FRAME_W] == '0);

   always_comb begin
      first = SPAN_W'(addr_ff[ADDR_W-1:FRAME_SHIFT]);
      last  = SPAN_W'(end_ff[ADDR_W-1:FRAME_SHIFT]);
      if (op_ff == OP_RFREE) begin
         first = first + SPAN_W'(|addr_ff[FRAME_SHIFT-1:0]);
      end else begin
         last = last + SPAN_W'(|end_ff[FRAME_SHIFT-1:0]);
      end
      last_c = (last > SPAN_W'(NUM_FRAMES)) ? SPAN_W'(NUM_FRAMES) : last;
   end

   assign cand    = ~bm_rdata_ff & ((row_ff == '0) ? ~ROW_BITS'(1) : '1);
   assign idx     = lowest_set(cand);
   assign lo_b    = (row_ff == lo_ff[FRAME_W-1:ROW_W]) ? lo_ff[ROW_W-1:0] : '0;
   assign hi_b    = (row_ff == hi_ff[FRAME_W-1:ROW_W]) ? hi_ff[ROW_W-1:0] : '1;
   assign mask    = ({ROW_BITS{1'b1}} << lo_b) & ({ROW_BITS{1'b1}} >> (~hi_b));
   assign new_row = (op_ff == OP_RUSED) ? (bm_rdata_ff | mask) : (bm_rdata_ff & ~mask);
   assign used    = bm_rdata_ff[frame[ROW_W-1:0]];

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      end_in        = end_ff;
      res_alloc_in  = res_alloc_ff;
      res_cnt_in    = res_cnt_ff;
      row_in        = row_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      delta_in      = delta_ff;
      pend_in       = 1'b0;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_alloc_in  = rsp_alloc_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_free_in   = rsp_free_ff;
      free_total_in = free_total_ff;
      bm_we    = 1'b0;
      bm_re    = 1'b0;
      bm_waddr = '0;
      bm_raddr = '0;
      bm_wdata = '0;
      rc_we    = 1'b0;
      rc_re    = 1'b0;
      rc_waddr = '0;
      rc_raddr = '0;
      rc_wdata = '0;

      if (pend_ff) begin
         free_total_in = (op_ff == OP_RFREE) ? free_total_ff + FREE_W'(delta_ff)
                                             : free_total_ff - FREE_W'(delta_ff);
      end

      unique case (state_ff)
         S_CLEAR: begin
            rc_we    = 1'b1;
            rc_waddr = clr_ff;
            if (clr_ff < FRAME_W'(ROWS)) begin
               bm_we    = 1'b1;
               bm_waddr = clr_ff[ROWS_W-1:0];
               bm_wdata = '1;
            end
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in        = req_op;
               addr_in      = req_addr;
               end_in       = req_end_addr;
               res_alloc_in = '0;
               res_cnt_in   = '0;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (op_ff)
               OP_ALLOC: begin
                  bm_re    = 1'b1;
                  bm_raddr = '0;
                  row_in   = '0;
                  state_in = S_SCAN;
               end
               OP_FREE, OP_ADDREF, OP_QUERY: begin
                  if (addr_ok) begin
                     bm_re    = 1'b1;
                     bm_raddr = frame[FRAME_W-1:ROW_W];
                     rc_re    = 1'b1;
                     rc_raddr = frame;
                     state_in = S_SINGLE;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               OP_RFREE, OP_RUSED: begin
                  if (first >= last_c) begin
                     state_in = S_DONE;
                  end else begin
                     lo_in    = first[FRAME_W-1:0];
                     hi_in    = FRAME_W'(last_c - 1'b1);
                     bm_re    = 1'b1;
                     bm_raddr = first[FRAME_W-1:ROW_W];
                     row_in   = first[FRAME_W-1:ROW_W];
                     state_in = S_RANGE;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SCAN: begin
            if (|cand) begin
               bm_we    = 1'b1;
               bm_waddr = row_ff;
               bm_wdata = bm_rdata_ff | (ROW_BITS'(1) << idx);
               rc_we    = 1'b1;
               rc_waddr = {row_ff, idx};
               rc_wdata = CNT_W'(1);
               free_total_in = free_total_ff - FREE_W'(1);
               res_alloc_in  = '0;
               res_alloc_in[FRAME_SHIFT +: FRAME_W] = {row_ff, idx};
               state_in = S_DONE;
            end else if (row_ff == '1) begin
               state_in = S_DONE;
            end else begin
               bm_re    = 1'b1;
               bm_raddr = row_ff + 1'b1;
               row_in   = row_ff + 1'b1;
            end
         end
         S_SINGLE: begin
            unique case (op_ff)
               OP_FREE: begin
                  if (used) begin
                     rc_we    = 1'b1;
                     rc_waddr = frame;
                     if (rc_rdata_ff > CNT_W'(1)) begin
                        rc_wdata = rc_rdata_ff - 1'b1;
                     end else begin
                        rc_wdata = '0;
                        bm_we    = 1'b1;
                        bm_waddr = frame[FRAME_W-1:ROW_W];
                        bm_wdata = bm_rdata_ff & ~(ROW_BITS'(1) << frame[ROW_W-1:0]);
                        free_total_in = free_total_ff + FREE_W'(1);
                     end
                  end
               end
               OP_ADDREF: begin
                  if (used && rc_rdata_ff != COUNT_MAX) begin
                     rc_we    = 1'b1;
                     rc_waddr = frame;
                     rc_wdata = rc_rdata_ff + 1'b1;
                  end
               end
               default: begin
                  res_cnt_in = used ? rc_rdata_ff : '0;
               end
            endcase
            state_in = S_DONE;
         end
         S_RANGE: begin
            bm_we    = 1'b1;
            bm_waddr = row_ff;
            bm_wdata = new_row;
            delta_in = popcount(new_row ^ bm_rdata_ff);
            pend_in  = 1'b1;
            if (row_ff == hi_ff[FRAME_W-1:ROW_W]) begin
               state_in = S_DRAIN;
            end else begin
               bm_re    = 1'b1;
               bm_raddr = row_ff + 1'b1;
               row_in   = row_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         default: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_alloc_in = res_alloc_ff;
               rsp_cnt_in   = res_cnt_ff;
               rsp_free_in  = free_total_ff;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         free_total_ff <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         free_total_ff <= free_total_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      addr_ff      <= addr_in;
      end_ff       <= end_in;
      res_alloc_ff <= res_alloc_in;
      res_cnt_ff   <= res_cnt_in;
      row_ff       <= row_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      delta_ff     <= delta_in;
      rsp_alloc_ff <= rsp_alloc_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_free_ff  <= rsp_free_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_alloc_addr  = rsp_alloc_ff;
   assign rsp_ref_count   = rsp_cnt_ff;
   assign rsp_free_frames = rsp_free_ff;

`ifndef SYNTHESIS
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_total_ff <= FREE_W'(NUM_FRAMES))
      else $error("free count above frame count");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside completion");

   a_bm_port_hazard: assert property (@(posedge clock) disable iff (reset)
      (bm_we && bm_re) |-> (bm_waddr != bm_raddr))
      else $error("bitmap read and write collide on one row");

   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && bm_we) |=> (free_total_ff == $past(free_total_ff) - FREE_W'(1)))
      else $error("allocation did not take one free frame");
`endif

endmodule

@@ tb/refcounted_frame_bitmap_allocator_tb.sv @@
// Testbench for the refcounted frame bitmap allocator: directed and random request streams.
`timescale 1ns / 1ps

module refcounted_frame_bitmap_allocator_tb;
   import rfba_pkg::*;

   localparam op_type OP_RSVD6 = 3'd6;
   localparam op_type OP_RSVD7 = 3'd7;
   localparam int HOLD_OFF = 600;
   localparam int SETTLE = 300;
   localparam int WINDOW = 1536;
   localparam int MAX_REPORTS = 10;
   localparam int SHARE_REFS = 20;

   typedef struct packed {
      addr_type alloc_addr;
      cnt_type  ref_count;
      free_type free_frames;
   } alloc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   op_type req_op = OP_ALLOC;
   addr_type req_addr = '0;
   addr_type req_end_addr = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   addr_type rsp_alloc_addr;
   cnt_type rsp_ref_count;
   free_type rsp_free_frames;

   bit frame_used [NUM_FRAMES];
   cnt_type frame_refs [NUM_FRAMES];
   int unsigned free_count = 0;
   alloc_result_type pending_results [$];
   addr_type granted [$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;

   refcounted_frame_bitmap_allocator uut (.*);

   initial begin
      for (int f = 0; f < NUM_FRAMES; f++) begin
         frame_used[f] = 1'b1;
         frame_refs[f] = '0;
      end
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic addr_type rand_addr();
      return addr_type'({$urandom(), $urandom()});
   endfunction

   function automatic bit frame_index(input addr_type a, output int unsigned fr);
      longint unsigned f;
      f = 64'(a >> FRAME_SHIFT);
      fr = 32'(f);
      return a != '0 && a[FRAME_SHIFT-1:0] == '0 && f < NUM_FRAMES;
   endfunction

   function automatic void mark_range(longint unsigned first, longint unsigned last,
                                      bit mark);
      if (last > NUM_FRAMES) last = NUM_FRAMES;
      for (longint unsigned f = first; f < last; f++) begin
         if (frame_used[f] != mark) begin
            frame_used[f] = mark;
            if (mark) free_count--;
            else free_count++;
         end
      end
   endfunction

   function automatic alloc_result_type apply_request(op_type op, addr_type addr,
                                                      addr_type stop_addr);
      alloc_result_type r;
      int unsigned fr;
      bit ok;
      bit found;
      longint unsigned first, last;
      r = '0;
      found = 1'b0;
      ok = frame_index(addr, fr);
      case (op)
         OP_ALLOC: begin
            for (int f = 1; f < NUM_FRAMES && !found; f++) begin
               if (!frame_used[f]) begin
                  found = 1'b1;
                  frame_used[f] = 1'b1;
                  free_count--;
                  frame_refs[f] = 16'd1;
                  r.alloc_addr = ADDR_W'(longint'(f) << FRAME_SHIFT);
               end
            end
         end
         OP_FREE: if (ok && frame_used[fr]) begin
            if (frame_refs[fr] > 16'd1) begin
               frame_refs[fr]--;
            end else begin
               frame_refs[fr] = '0;
               frame_used[fr] = 1'b0;
               free_count++;
            end
         end
         OP_ADDREF: if (ok && frame_used[fr] && frame_refs[fr] != COUNT_MAX) begin
            frame_refs[fr]++;
         end
         OP_QUERY: if (ok && frame_used[fr]) begin
            r.ref_count = frame_refs[fr];
         end
         OP_RFREE: begin
            first = 64'(addr >> FRAME_SHIFT) + 64'(addr[FRAME_SHIFT-1:0] != '0);
            last = 64'(stop_addr >> FRAME_SHIFT);
            mark_range(first, last, 1'b0);
         end
         OP_RUSED: begin
            first = 64'(addr >> FRAME_SHIFT);
            last = 64'(stop_addr >> FRAME_SHIFT) + 64'(stop_addr[FRAME_SHIFT-1:0] != '0);
            mark_range(first, last, 1'b1);
         end
         default: ;
      endcase
      r.free_frames = FREE_W'(free_count);
      return r;
   endfunction

   task automatic send_beat(op_type op, addr_type addr, addr_type stop_addr);
      alloc_result_type r;
      if ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_op = op;
      req_addr = addr;
      req_end_addr = stop_addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = apply_request(op, addr, stop_addr);
      pending_results.push_back(r);
      if (op == OP_ALLOC && r.alloc_addr != '0) granted.push_back(r.alloc_addr);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // receiver: long hold-off when requested, otherwise random stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected beat: addr %h count %h free %h",
                        rsp_alloc_addr, rsp_ref_count, rsp_free_frames);
         end else begin
            want = pending_results.pop_front();
            if (rsp_alloc_addr !== want.alloc_addr || rsp_ref_count !== want.ref_count ||
                rsp_free_frames !== want.free_frames) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("mismatch: expected addr %h count %h free %h, got %h %h %h",
                           want.alloc_addr, want.ref_count, want.free_frames,
                           rsp_alloc_addr, rsp_ref_count, rsp_free_frames);
            end
         end
      end
   end

   task automatic test_directed();
      send_idle_pct = 21;
      recv_idle_pct = 65;
      send_beat(OP_ALLOC, '0, '0);
      send_beat(OP_QUERY, 48'h1000, '0);
      send_beat(OP_ADDREF, 48'h1000, '0);
      send_beat(OP_QUERY, 48'h1000, '0);
      send_beat(OP_FREE, 48'h1000, '0);
      send_beat(OP_RFREE, 48'h0, 48'h8000);
      send_beat(OP_ALLOC, '0, '0);
      send_beat(OP_ALLOC, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      send_beat(OP_ADDREF, 48'h2000, '0);
      send_beat(OP_FREE, 48'h2000, '0);
      send_beat(OP_QUERY, 48'h2000, '0);
      send_beat(OP_FREE, 48'h2001, '0);
      send_beat(OP_FREE, 48'h0, '0);
      send_beat(OP_FREE, addr_type'(NUM_FRAMES) << FRAME_SHIFT, '0);
      send_beat(OP_FREE, 48'h5000, '0);
      send_beat(OP_QUERY, 48'hFFFF_FFFF_FFFF, '0);
      send_beat(OP_RFREE, 48'h8001, 48'hA000);
      send_beat(OP_RFREE, 48'h20000, 48'h10000);
      send_beat(OP_RUSED, 48'h3800, 48'h4001);
      send_beat(OP_RFREE, 48'hFFF_0000, 48'hFFFF_FFFF_FFFF);
      send_beat(OP_RUSED, 48'hFFF_8000, 48'hFFFF_FFFF_FFFF);
      send_beat(OP_RSVD6, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      send_beat(OP_RSVD7, 48'h1000, 48'h2000);
      send_beat(OP_ALLOC, '0, '0);
      wait_drained();
   endtask

   task automatic test_shared_count();
      addr_type fa;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_beat(OP_RFREE, 48'h40000, 48'h41000);
      send_beat(OP_ALLOC, '0, '0);
      fa = granted[$];
      for (int i = 0; i < SHARE_REFS; i++) send_beat(OP_ADDREF, fa, '0);
      send_beat(OP_QUERY, fa, '0);
      send_beat(OP_FREE, fa, '0);
      send_beat(OP_QUERY, fa, '0);
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_beat(OP_RFREE, 48'h0, 48'h20000);
      hold_left = HOLD_OFF;
      for (int i = 0; i < 30; i++) begin
         if (i % 3 == 2) send_beat(OP_QUERY, granted[$], '0);
         else send_beat(OP_ALLOC, '0, '0);
      end
      wait_drained();
   endtask

   task automatic send_random_item();
      int unsigned pick;
      int unsigned fr;
      int unsigned idx;
      addr_type a, b;
      pick = $urandom_range(99);
      fr = $urandom_range(WINDOW - 1);
      a = addr_type'(fr) << FRAME_SHIFT;
      b = a + (addr_type'($urandom_range(1, 48)) << FRAME_SHIFT);
      if ($urandom_range(3) == 0) a[FRAME_SHIFT-1:0] = FRAME_SHIFT'($urandom);
      if ($urandom_range(3) == 0) b[FRAME_SHIFT-1:0] = FRAME_SHIFT'($urandom);
      if (pick < 25) begin
         send_beat(OP_ALLOC, rand_addr(), rand_addr());
      end else if (pick < 45) begin
         if (granted.size() != 0 && $urandom_range(4) != 0) begin
            idx = $urandom_range(granted.size() - 1);
            a = granted[idx];
            if ($urandom_range(1) == 0) granted.delete(idx);
         end
         send_beat(OP_FREE, a, rand_addr());
      end else if (pick < 55) begin
         if (granted.size() != 0 && $urandom_range(3) != 0)
            a = granted[$urandom_range(granted.size() - 1)];
         send_beat(OP_ADDREF, a, rand_addr());
      end else if (pick < 68) begin
         if (granted.size() != 0 && $urandom_range(1) == 0)
            a = granted[$urandom_range(granted.size() - 1)];
         send_beat(OP_QUERY, a, rand_addr());
      end else if (pick < 78) begin
         send_beat(OP_RFREE, a, b);
      end else if (pick < 84) begin
         send_beat(OP_RUSED, a, b);
      end else if (pick < 86) begin
         a = rand_addr() >> $urandom_range(47);
         send_beat($urandom_range(1) ? OP_RFREE : OP_RUSED, a, rand_addr());
      end else begin
         send_beat(op_type'($urandom_range(7)), rand_addr(), rand_addr());
      end
   endtask

   task automatic test_random(int s_pct, int r_pct, int count);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int i = 0; i < count; i++) send_random_item();
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_shared_count();
      test_backpressure();
      test_random(21, 65, 120);
      test_random(65, 21, 120);
      test_random(0, 0, 120);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/rfba_pkg.sv
rtl/core/refcounted_frame_bitmap_allocator.sv
tb/refcounted_frame_bitmap_allocator_tb.sv
